>>> hw/rtl/chip8_instruction_core_defines.svh
// Assertion macros shared by the CHIP-8 core RTL.
`ifndef CHIP8_INSTRUCTION_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define C8IC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define C8IC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define C8IC_ASSERT(lbl, clk, rst_n, prop, msg)
`define C8IC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> hw/rtl/c8ic_pkg.sv
// Types, constants and helper functions of the CHIP-8 core.
`timescale 1ns / 1ps
package c8ic_pkg;

  localparam int ADDR_W      = 12;
  localparam int MEM_BYTES   = 4096;
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int SCR_BYTES   = 256;
  localparam int FONT_BASE   = 80;
  localparam int FONT_LEN    = 80;
  localparam logic [ADDR_W-1:0] PROG_START_RST = 12'h200;

  localparam logic [2:0] ALU_ADD  = 3'd0;
  localparam logic [2:0] ALU_SUB  = 3'd1;
  localparam logic [2:0] ALU_AND  = 3'd2;
  localparam logic [2:0] ALU_OR   = 3'd3;
  localparam logic [2:0] ALU_XOR  = 3'd4;
  localparam logic [2:0] ALU_SHR  = 3'd5;
  localparam logic [2:0] ALU_SHL  = 3'd6;
  localparam logic [2:0] ALU_PASS = 3'd7;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [15:0] key_states;
    logic [7:0]  random_byte;
  } c8ic_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [11:0] program_counter;
    logic [15:0] executed_opcode;
    logic        unknown_opcode;
    logic        waiting_for_key;
    logic        sound_on;
    logic        screen_changed;
  } c8ic_out_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
  } c8ic_alu_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] y;
    logic              flag;
  } c8ic_alu_rsp_t;

  localparam logic [7:0] GLYPHS [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] off;
    off = a - ADDR_W'(FONT_BASE);
    if (a >= ADDR_W'(FONT_BASE) && a < ADDR_W'(FONT_BASE + FONT_LEN)) begin
      return GLYPHS[off[6:0]];
    end
    return 8'h00;
  endfunction

  function automatic logic [ADDR_W-1:0] font_addr(input logic [3:0] d);
    return ADDR_W'(FONT_BASE) + {6'b0, d, 2'b00} + {8'b0, d};
  endfunction

  // found flag in the MSB, lowest held key below
  function automatic logic [4:0] key_pick(input logic [15:0] keys);
    logic [4:0] r;
    r = '0;
    for (int k = 15; k >= 0; k--) begin
      if (keys[k]) begin
        r = {1'b1, 4'(k)};
      end
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/c8ic_alu.sv
// Shared 12-bit arithmetic, logic and shift unit of the CHIP-8 core.
`timescale 1ns / 1ps
module c8ic_alu (
  input  c8ic_pkg::c8ic_alu_req_t req,
  output c8ic_pkg::c8ic_alu_rsp_t rsp
);
  import c8ic_pkg::*;

  logic [ADDR_W:0] sum;
  logic [ADDR_W:0] diff;

  assign sum  = {1'b0, req.a} + {1'b0, req.b};
  assign diff = {1'b0, req.a} - {1'b0, req.b};

  always_comb begin
    rsp.y    = '0;
    rsp.flag = 1'b0;
    unique case (req.op)
      ALU_ADD: begin
        rsp.y    = sum[ADDR_W-1:0];
        rsp.flag = sum[8];
      end
      ALU_SUB: begin
        rsp.y    = diff[ADDR_W-1:0];
        rsp.flag = !diff[ADDR_W];
      end
      ALU_AND: rsp.y = req.a & req.b;
      ALU_OR:  rsp.y = req.a | req.b;
      ALU_XOR: rsp.y = req.a ^ req.b;
      ALU_SHR: begin
        rsp.y    = {1'b0, req.a[ADDR_W-1:1]};
        rsp.flag = req.a[0];
      end
      ALU_SHL: begin
        rsp.y    = {req.a[ADDR_W-2:0], 1'b0};
        rsp.flag = req.a[7];
      end
      ALU_PASS: rsp.y = req.b;
    endcase
  end

endmodule

>>> hw/rtl/chip8_instruction_core.sv
// Top level of the CHIP-8 core: sequencer, memories, screen and registers.
//
// Input channel: an item (in_item) is taken when start is high and busy is low.
// Commands: step one instruction, write a memory byte, read a memory byte,
// read eight screen pixels. Every item gives one result on out_item, marked by
// out_strobe for exactly one cycle; the receiver cannot stall it.
// Configuration: cfg_data (program start) is written when cfg_valid and
// cfg_ready are high; cfg_ready is always high and the write also loads the PC.
// Instructions that write VF pass through an extra VF write state. CLS
// clears one screen byte per cycle, DRW works one sprite row at a time (one
// screen byte per row instead of two when the sprite starts in the rightmost
// byte column), BCD stores its three digits in turn, and Fx55/Fx65 move one
// register at a time. Busy drops in the strobe cycle, so the next item can be
// taken at the edge that ends it. Timing is set by the single-port fetch,
// the shared ALU and the one-byte-per-cycle screen memory.
// Reset: a clearing pass over all 4096 memory addresses loads the font,
// zeroes memory, screen and V registers; busy stays high until it ends.
`timescale 1ns / 1ps
`include "chip8_instruction_core_defines.svh"
module chip8_instruction_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  c8ic_pkg::c8ic_in_t  in_item,
  output logic                out_strobe,
  output c8ic_pkg::c8ic_out_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [11:0]         cfg_data
);
  import c8ic_pkg::*;

  localparam logic [1:0] CMD_STEP   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_SCREEN = 2'd3;

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_WRMEM   = 5'd2;
  localparam logic [4:0] S_RDMEM   = 5'd3;
  localparam logic [4:0] S_RDWAIT  = 5'd4;
  localparam logic [4:0] S_RDSCR   = 5'd5;
  localparam logic [4:0] S_SCRWAIT = 5'd6;
  localparam logic [4:0] S_FETCH_A = 5'd7;
  localparam logic [4:0] S_FETCH_B = 5'd8;
  localparam logic [4:0] S_FETCH_C = 5'd9;
  localparam logic [4:0] S_EXEC    = 5'd10;
  localparam logic [4:0] S_WRVF    = 5'd11;
  localparam logic [4:0] S_DONE    = 5'd12;
  localparam logic [4:0] S_CLS     = 5'd13;
  localparam logic [4:0] S_DRW_ROW = 5'd14;
  localparam logic [4:0] S_DRW_A   = 5'd15;
  localparam logic [4:0] S_DRW_B   = 5'd16;
  localparam logic [4:0] S_DRW_C   = 5'd17;
  localparam logic [4:0] S_BCD0    = 5'd18;
  localparam logic [4:0] S_BCD1    = 5'd19;
  localparam logic [4:0] S_BCD2    = 5'd20;
  localparam logic [4:0] S_BCD3    = 5'd21;
  localparam logic [4:0] S_ST_A    = 5'd22;
  localparam logic [4:0] S_ST_B    = 5'd23;
  localparam logic [4:0] S_LD_A    = 5'd24;
  localparam logic [4:0] S_LD_B    = 5'd25;

  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SEV  = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNEV = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'hA;
  localparam logic [3:0] GRP_JPV0 = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_SKP  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] A8_LD   = 4'h0;
  localparam logic [3:0] A8_OR   = 4'h1;
  localparam logic [3:0] A8_AND  = 4'h2;
  localparam logic [3:0] A8_XOR  = 4'h3;
  localparam logic [3:0] A8_ADD  = 4'h4;
  localparam logic [3:0] A8_SUB  = 4'h5;
  localparam logic [3:0] A8_SHR  = 4'h6;
  localparam logic [3:0] A8_SUBN = 4'h7;
  localparam logic [3:0] A8_SHL  = 4'hE;

  localparam logic [7:0] KK_SKP  = 8'h9E;
  localparam logic [7:0] KK_SKNP = 8'hA1;

  localparam logic [7:0] FX_LDVDT = 8'h07;
  localparam logic [7:0] FX_KEY   = 8'h0A;
  localparam logic [7:0] FX_LDDT  = 8'h15;
  localparam logic [7:0] FX_LDST  = 8'h18;
  localparam logic [7:0] FX_ADDI  = 8'h1E;
  localparam logic [7:0] FX_FONT  = 8'h29;
  localparam logic [7:0] FX_BCD   = 8'h33;
  localparam logic [7:0] FX_STORE = 8'h55;
  localparam logic [7:0] FX_LOAD  = 8'h65;

  logic [4:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [ADDR_W-1:0] pstart_r, pstart_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [7:0]        dt_r, dt_nxt;
  logic [7:0]        st_r, st_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              out_strobe_r, out_strobe_nxt;

  logic [15:0]       op_r, op_nxt;
  logic [3:0]        row_r, row_nxt;
  logic [7:0]        vx_r, vx_nxt;
  logic              flag_r, flag_nxt;
  logic              unk_r, unk_nxt;
  logic              wait_r, wait_nxt;
  logic              chg_r, chg_nxt;
  logic [7:0]        rdata_r, rdata_nxt;
  logic [1:0]        cmd_r, cmd_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]        wdata_r, wdata_nxt;
  logic [15:0]       keys_r, keys_nxt;
  logic [7:0]        rnd_r, rnd_nxt;
  logic [5:0]        dx_r, dx_nxt;
  logic [4:0]        dy_r, dy_nxt;
  logic [4:0]        ry_r, ry_nxt;
  logic [7:0]        line_r, line_nxt;
  logic [7:0]        dig_r, dig_nxt;
  logic [7:0]        rem_r, rem_nxt;
  c8ic_out_t         out_item_r, out_item_nxt;

  logic [ADDR_W-1:0] stk_r [STACK_DEPTH];
  logic              stk_we;

  logic [7:0]        mem [MEM_BYTES];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [7:0]        mem_wd, mem_q;

  logic [7:0]        vreg [16];
  logic              v_we;
  logic [3:0]        v_wa, va_ra, vb_ra;
  logic [7:0]        v_wd, va_q, vb_q;

  logic [7:0]        scr [SCR_BYTES];
  logic              s_we;
  logic [7:0]        s_wa, s_ra, s_wd, s_q;

  c8ic_alu_req_t     alu_req;
  c8ic_alu_rsp_t     alu_rsp;

  c8ic_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vreg[v_wa] <= v_wd;
    end
    va_q <= vreg[va_ra];
    vb_q <= vreg[vb_ra];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      scr[s_wa] <= s_wd;
    end
    s_q <= scr[s_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_r[sp_r] <= pc_r;
    end
  end

  always_comb begin
    logic [3:0]  grp;
    logic [3:0]  xi;
    logic [3:0]  nn;
    logic [7:0]  kk;
    logic [4:0]  kp;
    logic [5:0]  ysum;
    logic [15:0] shifted;
    logic [15:0] prod;
    logic [SP_W-1:0] sp_dec;
    logic [2:0]  col;

    grp     = op_r[15:12];
    xi      = op_r[11:8];
    nn      = op_r[3:0];
    kk      = op_r[7:0];
    kp      = key_pick(keys_r);
    ysum    = {1'b0, dy_r} + {2'b0, row_r};
    shifted = {line_r, 8'h00} >> dx_r[2:0];
    prod    = '0;
    sp_dec  = (sp_r == '0) ? SP_W'(STACK_DEPTH - 1) : sp_r - 1'b1;
    col     = dx_r[5:3];

    state_nxt      = state_r;
    pc_nxt         = pc_r;
    i_nxt          = i_r;
    pstart_nxt     = pstart_r;
    sp_nxt         = sp_r;
    dt_nxt         = dt_r;
    st_nxt         = st_r;
    cnt_nxt        = cnt_r;
    out_strobe_nxt = 1'b0;
    op_nxt         = op_r;
    row_nxt        = row_r;
    vx_nxt         = vx_r;
    flag_nxt       = flag_r;
    unk_nxt        = unk_r;
    wait_nxt       = wait_r;
    chg_nxt        = chg_r;
    rdata_nxt      = rdata_r;
    cmd_nxt        = cmd_r;
    addr_nxt       = addr_r;
    wdata_nxt      = wdata_r;
    keys_nxt       = keys_r;
    rnd_nxt        = rnd_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    ry_nxt         = ry_r;
    line_nxt       = line_r;
    dig_nxt        = dig_r;
    rem_nxt        = rem_r;
    out_item_nxt   = out_item_r;

    stk_we  = 1'b0;
    mem_we  = 1'b0;
    mem_wa  = addr_r;
    mem_wd  = wdata_r;
    mem_ra  = addr_r;
    v_we    = 1'b0;
    v_wa    = xi;
    v_wd    = 8'h00;
    va_ra   = xi;
    vb_ra   = op_r[7:4];
    s_we    = 1'b0;
    s_wa    = addr_r[7:0];
    s_wd    = 8'h00;
    s_ra    = addr_r[7:0];
    alu_req = '{op: ALU_ADD, a: pc_r, b: ADDR_W'(2)};

    unique case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = cnt_r;
        mem_wd  = font_byte(cnt_r);
        v_we    = 1'b1;
        v_wa    = cnt_r[3:0];
        s_we    = 1'b1;
        s_wa    = cnt_r[7:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ADDR_W'(MEM_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_item.command;
          addr_nxt  = in_item.address;
          wdata_nxt = in_item.write_data;
          keys_nxt  = in_item.key_states;
          rnd_nxt   = in_item.random_byte;
          rdata_nxt = 8'h00;
          op_nxt    = 16'h0000;
          unk_nxt   = 1'b0;
          wait_nxt  = 1'b0;
          chg_nxt   = 1'b0;
          unique case (in_item.command)
            CMD_WRITE:  state_nxt = S_WRMEM;
            CMD_READ:   state_nxt = S_RDMEM;
            CMD_SCREEN: state_nxt = S_RDSCR;
            CMD_STEP:   state_nxt = S_FETCH_A;
          endcase
        end
      end
      S_WRMEM: begin
        mem_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_RDMEM:   state_nxt = S_RDWAIT;
      S_RDWAIT: begin
        rdata_nxt = mem_q;
        state_nxt = S_DONE;
      end
      S_RDSCR:   state_nxt = S_SCRWAIT;
      S_SCRWAIT: begin
        rdata_nxt = s_q;
        state_nxt = S_DONE;
      end
      S_FETCH_A: begin
        mem_ra    = pc_r;
        state_nxt = S_FETCH_B;
      end
      S_FETCH_B: begin
        alu_req   = '{op: ALU_ADD, a: pc_r, b: ADDR_W'(1)};
        mem_ra    = alu_rsp.y;
        op_nxt    = {mem_q, op_r[7:0]};
        state_nxt = S_FETCH_C;
      end
      S_FETCH_C: begin
        op_nxt    = {op_r[15:8], mem_q};
        pc_nxt    = alu_rsp.y;
        va_ra     = (op_r[15:12] == GRP_JPV0) ? 4'h0 : op_r[11:8];
        vb_ra     = mem_q[7:4];
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (grp)
          GRP_SYS: begin
            if (op_r == OP_CLS) begin
              cnt_nxt   = '0;
              state_nxt = S_CLS;
            end else if (op_r == OP_RET) begin
              sp_nxt = sp_dec;
              pc_nxt = stk_r[sp_dec];
            end else begin
              unk_nxt = 1'b1;
            end
          end
          GRP_JP: pc_nxt = op_r[11:0];
          GRP_CALL: begin
            stk_we = 1'b1;
            sp_nxt = (sp_r == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_r + 1'b1;
            pc_nxt = op_r[11:0];
          end
          GRP_SE: begin
            if (va_q == kk) pc_nxt = alu_rsp.y;
          end
          GRP_SNE: begin
            if (va_q != kk) pc_nxt = alu_rsp.y;
          end
          GRP_SEV: begin
            if (nn != 4'h0) unk_nxt = 1'b1;
            else if (va_q == vb_q) pc_nxt = alu_rsp.y;
          end
          GRP_SNEV: begin
            if (nn != 4'h0) unk_nxt = 1'b1;
            else if (va_q != vb_q) pc_nxt = alu_rsp.y;
          end
          GRP_LD: begin
            v_we = 1'b1;
            v_wd = kk;
          end
          GRP_ADD: begin
            alu_req = '{op: ALU_ADD, a: {4'b0, va_q}, b: {4'b0, kk}};
            v_we    = 1'b1;
            v_wd    = alu_rsp.y[7:0];
          end
          GRP_ALU: begin
            alu_req  = '{op: ALU_PASS, a: {4'b0, va_q}, b: {4'b0, vb_q}};
            v_we     = 1'b1;
            v_wd     = alu_rsp.y[7:0];
            flag_nxt = alu_rsp.flag;
            unique case (nn)
              A8_LD:  alu_req.op = ALU_PASS;
              A8_OR:  alu_req.op = ALU_OR;
              A8_AND: alu_req.op = ALU_AND;
              A8_XOR: alu_req.op = ALU_XOR;
              A8_ADD: begin
                alu_req.op = ALU_ADD;
                state_nxt  = S_WRVF;
              end
              A8_SUB: begin
                alu_req.op = ALU_SUB;
                state_nxt  = S_WRVF;
              end
              A8_SHR: begin
                alu_req.op = ALU_SHR;
                alu_req.a  = {4'b0, vb_q};
                state_nxt  = S_WRVF;
              end
              A8_SUBN: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {4'b0, vb_q};
                alu_req.b  = {4'b0, va_q};
                state_nxt  = S_WRVF;
              end
              A8_SHL: begin
                alu_req.op = ALU_SHL;
                alu_req.a  = {4'b0, vb_q};
                state_nxt  = S_WRVF;
              end
              default: begin
                v_we    = 1'b0;
                unk_nxt = 1'b1;
              end
            endcase
          end
          GRP_LDI: i_nxt = op_r[11:0];
          GRP_JPV0: begin
            alu_req = '{op: ALU_ADD, a: op_r[11:0], b: {4'b0, va_q}};
            pc_nxt  = alu_rsp.y;
          end
          GRP_RND: begin
            v_we = 1'b1;
            v_wd = rnd_r & kk;
          end
          GRP_DRW: begin
            dx_nxt    = va_q[5:0];
            dy_nxt    = vb_q[4:0];
            row_nxt   = '0;
            flag_nxt  = 1'b0;
            state_nxt = S_DRW_ROW;
          end
          GRP_SKP: begin
            if (kk == KK_SKP) begin
              if (keys_r[va_q[3:0]]) pc_nxt = alu_rsp.y;
            end else if (kk == KK_SKNP) begin
              if (!keys_r[va_q[3:0]]) pc_nxt = alu_rsp.y;
            end else begin
              unk_nxt = 1'b1;
            end
          end
          GRP_MISC: begin
            unique case (kk)
              FX_LDVDT: begin
                v_we = 1'b1;
                v_wd = dt_r;
              end
              FX_KEY: begin
                if (kp[4]) begin
                  v_we = 1'b1;
                  v_wd = {4'b0, kp[3:0]};
                end else begin
                  wait_nxt = 1'b1;
                  alu_req  = '{op: ALU_SUB, a: pc_r, b: ADDR_W'(2)};
                  pc_nxt   = alu_rsp.y;
                end
              end
              FX_LDDT: dt_nxt = va_q;
              FX_LDST: st_nxt = va_q;
              FX_ADDI: begin
                alu_req = '{op: ALU_ADD, a: i_r, b: {4'b0, va_q}};
                i_nxt   = alu_rsp.y;
              end
              FX_FONT: i_nxt = font_addr(va_q[3:0]);
              FX_BCD: begin
                vx_nxt    = va_q;
                state_nxt = S_BCD0;
              end
              FX_STORE: begin
                cnt_nxt   = '0;
                state_nxt = S_ST_A;
              end
              FX_LOAD: begin
                cnt_nxt   = '0;
                state_nxt = S_LD_A;
              end
              default: unk_nxt = 1'b1;
            endcase
          end
        endcase
      end
      S_WRVF: begin
        v_we      = 1'b1;
        v_wa      = 4'hF;
        v_wd      = {7'b0, flag_r};
        state_nxt = S_DONE;
      end
      S_CLS: begin
        s_ra    = cnt_r[7:0];
        cnt_nxt = cnt_r + 1'b1;
        if (!cnt_r[8]) begin
          s_we = 1'b1;
          s_wa = cnt_r[7:0];
        end else begin
          state_nxt = S_DONE;
        end
        if (cnt_r != '0 && s_q != 8'h00) chg_nxt = 1'b1;
      end
      S_DRW_ROW: begin
        alu_req = '{op: ALU_ADD, a: i_r, b: {8'b0, row_r}};
        mem_ra  = alu_rsp.y;
        ry_nxt  = ysum[4:0];
        if (row_r == nn || ysum[5]) begin
          state_nxt = S_WRVF;
        end else begin
          state_nxt = S_DRW_A;
        end
      end
      S_DRW_A: begin
        line_nxt  = mem_q;
        s_ra      = {ry_r, col};
        state_nxt = S_DRW_B;
      end
      S_DRW_B: begin
        s_we = 1'b1;
        s_wa = {ry_r, col};
        s_wd = s_q ^ shifted[15:8];
        s_ra = {ry_r, col + 3'd1};
        if ((s_q & shifted[15:8]) != 8'h00) flag_nxt = 1'b1;
        if (shifted[15:8] != 8'h00) chg_nxt = 1'b1;
        if (col == 3'd7) begin
          row_nxt   = row_r + 1'b1;
          state_nxt = S_DRW_ROW;
        end else begin
          state_nxt = S_DRW_C;
        end
      end
      S_DRW_C: begin
        s_we = 1'b1;
        s_wa = {ry_r, col + 3'd1};
        s_wd = s_q ^ shifted[7:0];
        if ((s_q & shifted[7:0]) != 8'h00) flag_nxt = 1'b1;
        if (shifted[7:0] != 8'h00) chg_nxt = 1'b1;
        row_nxt   = row_r + 1'b1;
        state_nxt = S_DRW_ROW;
      end
      S_BCD0: begin
        prod      = {8'b0, vx_r} * 16'd41;
        dig_nxt   = {4'b0, prod[15:12]};
        state_nxt = S_BCD1;
      end
      S_BCD1: begin
        prod      = {8'b0, dig_r} * 16'd100;
        rem_nxt   = vx_r - prod[7:0];
        mem_we    = 1'b1;
        mem_wa    = i_r;
        mem_wd    = dig_r;
        state_nxt = S_BCD2;
      end
      S_BCD2: begin
        prod      = {8'b0, rem_r} * 16'd205;
        dig_nxt   = {3'b0, prod[15:11]};
        alu_req   = '{op: ALU_ADD, a: i_r, b: ADDR_W'(1)};
        mem_we    = 1'b1;
        mem_wa    = alu_rsp.y;
        mem_wd    = {3'b0, prod[15:11]};
        state_nxt = S_BCD3;
      end
      S_BCD3: begin
        prod      = {8'b0, dig_r} * 16'd10;
        alu_req   = '{op: ALU_ADD, a: i_r, b: ADDR_W'(2)};
        mem_we    = 1'b1;
        mem_wa    = alu_rsp.y;
        mem_wd    = rem_r - prod[7:0];
        state_nxt = S_DONE;
      end
      S_ST_A: begin
        va_ra     = cnt_r[3:0];
        state_nxt = S_ST_B;
      end
      S_ST_B: begin
        alu_req = '{op: ALU_ADD, a: i_r, b: cnt_r};
        mem_we  = 1'b1;
        mem_wa  = alu_rsp.y;
        mem_wd  = va_q;
        if (cnt_r[3:0] == xi) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_ST_A;
        end
      end
      S_LD_A: begin
        alu_req   = '{op: ALU_ADD, a: i_r, b: cnt_r};
        mem_ra    = alu_rsp.y;
        state_nxt = S_LD_B;
      end
      S_LD_B: begin
        v_we = 1'b1;
        v_wa = cnt_r[3:0];
        v_wd = mem_q;
        if (cnt_r[3:0] == xi) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_LD_A;
        end
      end
      S_DONE: begin
        if (cmd_r == CMD_STEP) begin
          if (dt_r != 8'h00) dt_nxt = dt_r - 1'b1;
          if (st_r != 8'h00) st_nxt = st_r - 1'b1;
        end
        out_item_nxt.read_data       = rdata_r;
        out_item_nxt.program_counter = pc_r;
        out_item_nxt.executed_opcode = op_r;
        out_item_nxt.unknown_opcode  = unk_r;
        out_item_nxt.waiting_for_key = wait_r;
        out_item_nxt.sound_on        = (st_nxt != 8'h00);
        out_item_nxt.screen_changed  = chg_r;
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_valid) begin
      pstart_nxt = cfg_data;
      pc_nxt     = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      pc_r         <= PROG_START_RST;
      i_r          <= '0;
      pstart_r     <= PROG_START_RST;
      sp_r         <= '0;
      dt_r         <= '0;
      st_r         <= '0;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pc_r         <= pc_nxt;
      i_r          <= i_nxt;
      pstart_r     <= pstart_nxt;
      sp_r         <= sp_nxt;
      dt_r         <= dt_nxt;
      st_r         <= st_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    row_r      <= row_nxt;
    vx_r       <= vx_nxt;
    flag_r     <= flag_nxt;
    unk_r      <= unk_nxt;
    wait_r     <= wait_nxt;
    chg_r      <= chg_nxt;
    rdata_r    <= rdata_nxt;
    cmd_r      <= cmd_nxt;
    addr_r     <= addr_nxt;
    wdata_r    <= wdata_nxt;
    keys_r     <= keys_nxt;
    rnd_r      <= rnd_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    ry_r       <= ry_nxt;
    line_r     <= line_nxt;
    dig_r      <= dig_nxt;
    rem_r      <= rem_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  `C8IC_ASSERT(a_strobe_single, clk, rst_n, out_strobe |=> !out_strobe, "strobe held two cycles")
  `C8IC_ASSERT(a_accept_busy, clk, rst_n, start && !busy |=> busy, "accepted item left core idle")
  `C8IC_ASSERT_NEVER(a_clear_quiet, clk, rst_n, (state_r == S_CLEAR) && out_strobe, "result in clear")
  `C8IC_ASSERT(a_sp_exec_only, clk, rst_n, (state_r != S_EXEC) |=> $stable(sp_r), "sp moved")

endmodule
